### src/mip_pkg.sv
// Shared types and constants of the maximum intensity projection block.
// Depends on nothing; every other file except mip_ram uses it by scoped names.
package mip_pkg;

    localparam int VOL_DIM   = 256;
    localparam int IMG_SIZE  = 256;
    localparam int FRAC_BITS = 14;

    localparam int FIELD_W   = 8;
    localparam int COEF_W    = 16;
    localparam int OFF_W     = 32;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;
    localparam int PIX_W     = $clog2(IMG_SIZE);
    localparam int IMG_DEPTH = IMG_SIZE * IMG_SIZE;
    localparam int ADDR_W    = $clog2(IMG_DEPTH);
    localparam int PROD_W    = COEF_W + FIELD_W + 1;
    localparam int ACC_W     = OFF_W + 2;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_BITS);

    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_UX  = 3'd0,
        REG_COEF_UY  = 3'd1,
        REG_COEF_UZ  = 3'd2,
        REG_COEF_VX  = 3'd3,
        REG_COEF_VY  = 3'd4,
        REG_COEF_VZ  = 3'd5,
        REG_U_OFFSET = 3'd6,
        REG_V_OFFSET = 3'd7
    } mip_reg_t;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] vox_x;
        logic [FIELD_W-1:0] vox_y;
        logic [FIELD_W-1:0] vox_z;
        logic [FIELD_W-1:0] voxel_value;
        logic [FIELD_W-1:0] pix_row;
        logic [FIELD_W-1:0] pix_col;
    } mip_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] pixel_value;
        logic               off_image;
    } mip_out_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_ux;
        logic signed [COEF_W-1:0] coef_uy;
        logic signed [COEF_W-1:0] coef_uz;
        logic signed [COEF_W-1:0] coef_vx;
        logic signed [COEF_W-1:0] coef_vy;
        logic signed [COEF_W-1:0] coef_vz;
        logic signed [OFF_W-1:0]  u_offset;
        logic signed [OFF_W-1:0]  v_offset;
    } mip_cfg_t;

    typedef struct packed {
        logic             off;
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] col;
    } mip_proj_t;

endpackage

### src/max_intensity_projection.sv
// Top level of the maximum intensity projection block: control, registers, image store.
// Depends on mip_pkg, mip_proj and mip_ram.
//
// channel  signals                          role
// in       in_valid, in_ready, in_data      voxel or pixel-read item
// out      out_valid, out_ready, out_data   pixel value and off-image flag
// cfg      cfg_we, cfg_index, cfg_data      register write, no wait
//
// An accumulate passes through accept, multiply, sum, store read and store write;
// a read through accept, store read and store write. The image store's single
// read and write port sets the pace. After reset the store is zeroed, in_ready low.
// A result waits in the output register; the next item is accepted meanwhile and
// holds in the store-write step only while the previous result is not taken.
module max_intensity_projection (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  mip_pkg::mip_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output mip_pkg::mip_out_t         out_data,
    input  logic                      cfg_we,
    input  logic [mip_pkg::IDX_W-1:0] cfg_index,
    input  logic [mip_pkg::DATA_W-1:0] cfg_data
);

    localparam int AW = mip_pkg::ADDR_W;
    localparam int FW = mip_pkg::FIELD_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MUL   = 6'b000100,
        S_ADD   = 6'b001000,
        S_READ  = 6'b010000,
        S_WRITE = 6'b100000
    } mip_state_t;

    mip_state_t         state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    mip_pkg::mip_in_t   item_reg, item_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic               off_reg, off_next;
    mip_pkg::mip_out_t  out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    mip_pkg::mip_cfg_t  cfg_reg;
    mip_pkg::mip_proj_t proj;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [FW-1:0]      ram_wdata, ram_rdata;
    logic               out_free, rd_off;
    logic [AW-1:0]      rd_addr, acc_addr;
    logic [FW-1:0]      max_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_ux  <= mip_pkg::COEF_ONE;
            cfg_reg.coef_uy  <= '0;
            cfg_reg.coef_uz  <= '0;
            cfg_reg.coef_vx  <= '0;
            cfg_reg.coef_vy  <= mip_pkg::COEF_ONE;
            cfg_reg.coef_vz  <= '0;
            cfg_reg.u_offset <= '0;
            cfg_reg.v_offset <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mip_pkg::REG_COEF_UX:  cfg_reg.coef_ux  <= cfg_data[mip_pkg::COEF_W-1:0];
                mip_pkg::REG_COEF_UY:  cfg_reg.coef_uy  <= cfg_data[mip_pkg::COEF_W-1:0];
                mip_pkg::REG_COEF_UZ:  cfg_reg.coef_uz  <= cfg_data[mip_pkg::COEF_W-1:0];
                mip_pkg::REG_COEF_VX:  cfg_reg.coef_vx  <= cfg_data[mip_pkg::COEF_W-1:0];
                mip_pkg::REG_COEF_VY:  cfg_reg.coef_vy  <= cfg_data[mip_pkg::COEF_W-1:0];
                mip_pkg::REG_COEF_VZ:  cfg_reg.coef_vz  <= cfg_data[mip_pkg::COEF_W-1:0];
                mip_pkg::REG_U_OFFSET: cfg_reg.u_offset <= cfg_data[mip_pkg::OFF_W-1:0];
                mip_pkg::REG_V_OFFSET: cfg_reg.v_offset <= cfg_data[mip_pkg::OFF_W-1:0];
            endcase
        end
    end

    mip_proj u_proj (
        .clk    (clk),
        .cfg    (cfg_reg),
        .vox_x  (item_reg.vox_x),
        .vox_y  (item_reg.vox_y),
        .vox_z  (item_reg.vox_z),
        .mul_en (state_reg == S_MUL),
        .sum_en (state_reg == S_ADD),
        .result (proj)
    );

    mip_ram #(
        .WIDTH (FW),
        .DEPTH (mip_pkg::IMG_DEPTH)
    ) u_image (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_next),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        acc_addr = AW'(proj.row) * AW'(mip_pkg::IMG_SIZE) + AW'(proj.col);
        rd_addr  = AW'(item_reg.pix_row) * AW'(mip_pkg::IMG_SIZE) + AW'(item_reg.pix_col);
        max_val  = (item_reg.voxel_value > ram_rdata) ? item_reg.voxel_value : ram_rdata;
        out_free = !out_valid_reg || out_ready;
        rd_off   = (32'(item_reg.pix_row) >= mip_pkg::IMG_SIZE) ||
                   (32'(item_reg.pix_col) >= mip_pkg::IMG_SIZE);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        item_next      = item_reg;
        addr_next      = addr_reg;
        off_next       = off_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(mip_pkg::IMG_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = (in_data.action == mip_pkg::ACT_READ) ? S_READ : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                if (item_reg.action == mip_pkg::ACT_READ)
                begin
                    off_next  = rd_off;
                    addr_next = rd_addr;
                end
                else
                begin
                    off_next  = proj.off;
                    addr_next = acc_addr;
                end
                ram_re     = !off_next;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (off_reg)
                    begin
                        out_next.pixel_value = '0;
                        out_next.off_image   = 1'b1;
                    end
                    else if (item_reg.action == mip_pkg::ACT_READ)
                    begin
                        ram_we               = 1'b1;
                        out_next.pixel_value = ram_rdata;
                        out_next.off_image   = 1'b0;
                    end
                    else
                    begin
                        ram_we               = 1'b1;
                        ram_wdata            = max_val;
                        out_next.pixel_value = max_val;
                        out_next.off_image   = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        addr_reg <= addr_next;
        off_reg  <= off_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### src/mip_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module mip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/mip_proj.sv
// Voxel projection unit: six products in one stage, sums and pixel range check
// in the next. Depends on mip_pkg.
module mip_proj (
    input  logic                        clk,
    input  mip_pkg::mip_cfg_t           cfg,
    input  logic [mip_pkg::FIELD_W-1:0] vox_x,
    input  logic [mip_pkg::FIELD_W-1:0] vox_y,
    input  logic [mip_pkg::FIELD_W-1:0] vox_z,
    input  logic                        mul_en,
    input  logic                        sum_en,
    output mip_pkg::mip_proj_t          result
);

    localparam int PW = mip_pkg::PROD_W;
    localparam int AW = mip_pkg::ACC_W;
    localparam int FB = mip_pkg::FRAC_BITS;
    localparam int HW = AW - 1 - FB;

    logic signed [PW-1:0] pux_reg, puy_reg, puz_reg, pvx_reg, pvy_reg, pvz_reg;
    logic                 vol_off_reg;
    logic signed [mip_pkg::FIELD_W:0] sx, sy, sz;
    logic signed [AW-1:0] u_acc, v_acc;
    logic                 u_ok, v_ok;
    mip_pkg::mip_proj_t   result_reg;

    assign sx = $signed({1'b0, vox_x});
    assign sy = $signed({1'b0, vox_y});
    assign sz = $signed({1'b0, vox_z});

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            pux_reg     <= PW'(cfg.coef_ux * sx);
            puy_reg     <= PW'(cfg.coef_uy * sy);
            puz_reg     <= PW'(cfg.coef_uz * sz);
            pvx_reg     <= PW'(cfg.coef_vx * sx);
            pvy_reg     <= PW'(cfg.coef_vy * sy);
            pvz_reg     <= PW'(cfg.coef_vz * sz);
            vol_off_reg <= (32'(vox_x) >= mip_pkg::VOL_DIM) ||
                           (32'(vox_y) >= mip_pkg::VOL_DIM) ||
                           (32'(vox_z) >= mip_pkg::VOL_DIM);
        end
    end

    always_comb
    begin
        u_acc = AW'(pux_reg) + AW'(puy_reg) + AW'(puz_reg) + AW'(cfg.u_offset);
        v_acc = AW'(pvx_reg) + AW'(pvy_reg) + AW'(pvz_reg) + AW'(cfg.v_offset);
        u_ok  = !u_acc[AW-1] && (u_acc[AW-2:FB] < HW'(mip_pkg::IMG_SIZE));
        v_ok  = !v_acc[AW-1] && (v_acc[AW-2:FB] < HW'(mip_pkg::IMG_SIZE));
    end

    always_ff @(posedge clk)
    begin
        if (sum_en)
        begin
            result_reg.off <= vol_off_reg || !u_ok || !v_ok;
            result_reg.col <= u_acc[FB +: mip_pkg::PIX_W];
            result_reg.row <= v_acc[FB +: mip_pkg::PIX_W];
        end
    end

    assign result = result_reg;

endmodule
